@@ hw/rtl/pipc_pkg.sv @@
// Package for the PI position controller: constants, register codes and setpoint table.
package pipc_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN     = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_INTEGRAL_GAIN = 1'b1;

  localparam int unsigned GainW  = 10;
  localparam int unsigned SpW    = 14;
  localparam int unsigned ErrW   = 18;
  localparam int unsigned IlimW  = 30;
  localparam int unsigned IntegW = 32;

  localparam logic [GainW-1:0] GAIN_RESET_P = 10'd1000;
  localparam logic [GainW-1:0] GAIN_RESET_I = 10'd0;

  // Position mapping
  localparam int unsigned SPAN_TOTAL  = 10000;
  localparam int unsigned SAFE_MARGIN = 200;
  localparam int unsigned POS_FULL    = 255;
  localparam int unsigned POS_LOW     = 10;
  localparam int unsigned POS_HIGH    = 245;

  // I term limits; 2^30 - 1 is both the base of the sum limit and the clamped I term
  localparam logic [IlimW-1:0] I_TERM_MAX = 30'h3FFF_FFFF;

  // Drive: divide by 8000 = 64 * 125, the odd part by reciprocal multiply
  localparam int unsigned DRIVE_PRE_SHIFT = 6;
  localparam int unsigned DRIVE_ODD       = 125;
  localparam int unsigned RECIP_SHIFT     = 32;
  localparam logic [25:0] RECIP_MUL       = 26'((64'd1 << RECIP_SHIFT) / DRIVE_ODD);
  localparam logic [15:0] DRIVE_MAX       = 16'd32767;

  typedef logic [SpW-1:0] sp_lut_t [256];

  // Clamped position byte to setpoint, worked out at elaboration
  function automatic sp_lut_t build_sp_lut();
    sp_lut_t     lut;
    int unsigned pc;
    for (int unsigned p = 0; p < 256; p++) begin
      pc = p;
      if (pc < POS_LOW) pc = POS_LOW;
      if (pc > POS_HIGH) pc = POS_HIGH;
      lut[p] = SpW'((SPAN_TOTAL - 2 * SAFE_MARGIN) * pc / POS_FULL + SAFE_MARGIN);
    end
    return lut;
  endfunction

  localparam sp_lut_t SETPOINT_LUT = build_sp_lut();

endpackage

@@ hw/rtl/pi_position_controller.sv @@
// PI position controller: pipelined error, P/I terms and saturated drive output.
//
// One beat in, one beat out. A new beat is taken every cycle unless the limit division is
// busy or back-pressure from m_axis_tready reaches the input; the input register loads at the
// accepting edge and the result then passes the error, P/I term, quotient estimate and output
// registers, and the stages stall only as far back as a full stage meets a stalled one. The
// integral sum is updated in the term stage, so back-to-back beats see each other's sums.
// Writing integral_gain starts a restoring division of 2^30-1 by (gain+1) for the sum limit; while it
// runs s_axis_tready is low. prop_gain takes effect at once: with a 16-bit count
// and a 10-bit gain the error never reaches 2^31/(gain+1), so the P term is always
// gain*error and its saturation limit needs no storage. The drive is (P+I)/8000
// truncated toward zero, done as a shift by 6 and a reciprocal multiply by 1/125
// with one correction step, then clamped to +-32767.
module pi_position_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // target_position [7:0], encoder_count [23:8]
  input  logic [23:0]                    s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // drive [15:0]
  output logic [15:0]                    m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [pipc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pipc_pkg::GainW-1:0]     cfg_data_i
);
  import pipc_pkg::*;

  // ---------------- configuration and limit divider ----------------
  logic [GainW-1:0] kp_q, ki_q;
  logic [IlimW-1:0] ilim_q;
  logic             busy_q;
  logic [4:0]       dcnt_q;
  logic [GainW:0]   rem_q, rem_d;
  logic [IlimW-1:0] dquo_q, dquo_d;
  logic [GainW:0]   dsr;
  logic [GainW+1:0] trial;
  logic             qbit;

  assign dsr   = {1'b0, ki_q} + 11'd1;
  // dividend is all ones, so a one is shifted in at every step
  assign trial = {rem_q, 1'b1};

  always_comb begin
    qbit  = trial >= {1'b0, dsr};
    rem_d = qbit ? 11'(trial - {1'b0, dsr}) : trial[GainW:0];
    dquo_d = {dquo_q[IlimW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= GAIN_RESET_P;
      ki_q   <= GAIN_RESET_I;
      ilim_q <= I_TERM_MAX;
      busy_q <= 1'b0;
      dcnt_q <= '0;
      rem_q  <= '0;
      dquo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN: begin
          kp_q <= cfg_data_i;
        end
        REG_INTEGRAL_GAIN: begin
          ki_q   <= cfg_data_i;
          busy_q <= 1'b1;
          dcnt_q <= 5'(IlimW - 1);
          rem_q  <= '0;
          dquo_q <= '0;
        end
        default: begin
        end
      endcase
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dquo_q <= dquo_d;
      dcnt_q <= dcnt_q - 5'd1;
      if (dcnt_q == '0) begin
        busy_q <= 1'b0;
        ilim_q <= dquo_d;
      end
    end
  end

  // ---------------- pipeline handshake ----------------
  logic v_in_q, v_err_q, v_trm_q, v_quo_q, v_out_q;
  logic adv_out, adv_quo, adv_trm, adv_err, adv_in;

  assign adv_out = !v_out_q || m_axis_tready;
  assign adv_quo = !v_quo_q || adv_out;
  assign adv_trm = !v_trm_q || adv_quo;
  assign adv_err = !v_err_q || adv_trm;
  assign adv_in  = !v_in_q  || adv_err;

  assign s_axis_tready = adv_in && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q  <= 1'b0;
      v_err_q <= 1'b0;
      v_trm_q <= 1'b0;
      v_quo_q <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      if (adv_in)  v_in_q  <= s_axis_tvalid && !busy_q;
      if (adv_err) v_err_q <= v_in_q;
      if (adv_trm) v_trm_q <= v_err_q;
      if (adv_quo) v_quo_q <= v_trm_q;
      if (adv_out) v_out_q <= v_quo_q;
    end
  end

  // ---------------- input register ----------------
  logic [7:0]         pos_q;
  logic signed [15:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pos_q <= s_axis_tdata[7:0];
      cnt_q <= $signed(s_axis_tdata[23:8]);
    end
  end

  // ---------------- error stage ----------------
  logic signed [ErrW-1:0] err_q, err_d;

  assign err_d = $signed({4'b0, SETPOINT_LUT[pos_q]}) - ErrW'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (adv_err && v_in_q) err_q <= err_d;
  end

  // ---------------- term stage, integral update ----------------
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [IntegW:0]   sum, lim_pos, lim_neg;
  logic signed [28:0]       p_q, p_d;
  logic signed [31:0]       i_q, i_d;
  logic signed [43:0]       i_prod;
  logic                     upd;

  assign upd     = v_err_q && adv_trm;
  assign sum     = {integ_q[IntegW-1], integ_q} + 33'(err_q);
  assign lim_pos = $signed({3'b0, ilim_q});
  assign lim_neg = -lim_pos;
  assign i_prod  = $signed({1'b0, ki_q}) * sum;
  assign p_d     = $signed({1'b0, kp_q}) * err_q;

  always_comb begin
    if (sum > lim_pos) begin
      integ_d = 32'(lim_pos);
      i_d     = $signed({2'b0, I_TERM_MAX});
    end else if (sum < lim_neg) begin
      integ_d = 32'(lim_neg);
      i_d     = -$signed({2'b0, I_TERM_MAX});
    end else begin
      integ_d = 32'(sum);
      i_d     = 32'(i_prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (upd) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      p_q <= p_d;
      i_q <= i_d;
    end
  end

  // ---------------- quotient estimate stage ----------------
  logic signed [32:0] tot;
  logic [31:0]        mag;
  logic [24:0]        b_d, b_q;
  logic [50:0]        rprod;
  logic [18:0]        q0_q;
  logic               neg_q;

  assign tot   = 33'(p_q) + 33'(i_q);
  assign mag   = tot[32] ? 32'(-tot) : 32'(tot);
  assign b_d   = 25'(mag >> DRIVE_PRE_SHIFT);
  assign rprod = 51'(b_d) * 51'(RECIP_MUL);

  always_ff @(posedge clk_i) begin
    if (adv_quo && v_trm_q) begin
      b_q   <= b_d;
      q0_q  <= rprod[50:RECIP_SHIFT];
      neg_q <= tot[32];
    end
  end

  // ---------------- correction, clamp, output register ----------------
  logic [25:0] rem_f;
  logic [19:0] qfix;
  logic [15:0] dmag;
  logic [15:0] drive_q;

  assign rem_f = 26'(b_q) - 26'(q0_q) * 26'(DRIVE_ODD);
  assign qfix  = 20'(q0_q) + ((rem_f >= 26'(DRIVE_ODD)) ? 20'd1 : 20'd0);
  assign dmag  = (qfix > 20'(DRIVE_MAX)) ? DRIVE_MAX : qfix[15:0];

  always_ff @(posedge clk_i) begin
    if (adv_out && v_quo_q) drive_q <= neg_q ? -dmag : dmag;
  end

  assign m_axis_tdata  = drive_q;
  assign m_axis_tvalid = v_out_q;

  // ---------------- assertions ----------------
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready)
    else $error("beat accepted during limit division");

  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(upd) && $stable(ilim_q) |->
      ((33'(integ_q) <= lim_pos) && (33'(integ_q) >= lim_neg)))
    else $error("integral sum outside its limit");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata != 16'h8000))
    else $error("drive outside +-32767");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v_out_q) |-> $past(v_quo_q))
    else $error("result without a quotient beat");

endmodule
